@@ rtl/alto_pkg.sv @@
// ----------------------------------------------------------------------------
// alto_pkg
// Shared types, constants and the microcode program for the asymmetric leaky
// integrator with threshold-linear output.
// ----------------------------------------------------------------------------
`default_nettype none

package alto_pkg;

   // number formats
   localparam int DATA_WIDTH  = 32;
   localparam int FRAC_BITS   = 16;
   localparam int COEFF_FRAC  = 16;
   localparam int COEFF_WIDTH = COEFF_FRAC + 1;
   localparam int DRIVE_WIDTH = 31;
   localparam int OUT_WIDTH   = 31;
   localparam int CAP_WIDTH   = 31;

   // multiplier operand and product widths
   localparam int MUL_A_WIDTH = DATA_WIDTH + 2;
   localparam int MUL_B_WIDTH = DATA_WIDTH;
   localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;

   // serial divider: the quotient of (excite << FRAC_BITS) / (1.0 + inhibit)
   // is below 2^DRIVE_WIDTH, so only that many quotient bits are developed
   localparam int DIV_BITS    = DRIVE_WIDTH;
   localparam int CNT_WIDTH   = $clog2(DIV_BITS);

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 3;
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RISE_COEFF      = 3'd0,
      CSR_FALL_COEFF      = 3'd1,
      CSR_THRESHOLD_LEVEL = 3'd2,
      CSR_AMPLITUDE_SLOPE = 3'd3,
      CSR_OUTPUT_BIAS     = 3'd4,
      CSR_RAMP_INCREMENT  = 3'd5,
      CSR_OUTPUT_CAP      = 3'd6,
      CSR_CONTROL_GAIN    = 3'd7
   } csr_index_type;

   // payloads
   typedef struct packed {
      logic [DRIVE_WIDTH-1:0] excite_drive;
      logic [DRIVE_WIDTH-1:0] inhibit_drive;
   } req_payload_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] output_value;
      logic                 above_threshold;
   } rsp_payload_type;

   // datapath operations
   typedef enum logic [4:0] {
      OP_NOP,
      OP_WAIT,
      OP_DIV,
      OP_QUOT,
      OP_MUL_RISE,
      OP_MUL_FALL,
      OP_UP,
      OP_ACT,
      OP_THR,
      OP_MUL_SLOPE,
      OP_MRES,
      OP_ADD_BIAS,
      OP_ADD_RAMP,
      OP_MUL_GAIN,
      OP_CLAMP,
      OP_ZERO,
      OP_EMIT
   } op_type;

   // jump conditions
   typedef enum logic [2:0] {
      JC_NONE,
      JC_ALWAYS,
      JC_NO_REQ,
      JC_DIV_LOOP,
      JC_NOT_ABOVE,
      JC_OUT_BUSY
   } jcond_type;

   // program steps
   localparam int STEP_WIDTH = 5;
   typedef logic [STEP_WIDTH-1:0] step_type;

   localparam step_type STEP_WAIT      = 5'd0;
   localparam step_type STEP_DIV       = 5'd1;
   localparam step_type STEP_QUOT      = 5'd2;
   localparam step_type STEP_MUL_RISE  = 5'd3;
   localparam step_type STEP_MUL_FALL  = 5'd4;
   localparam step_type STEP_UP        = 5'd5;
   localparam step_type STEP_ACT       = 5'd6;
   localparam step_type STEP_THR       = 5'd7;
   localparam step_type STEP_MUL_SLOPE = 5'd8;
   localparam step_type STEP_MRES_A    = 5'd9;
   localparam step_type STEP_ADD_BIAS  = 5'd10;
   localparam step_type STEP_ADD_RAMP  = 5'd11;
   localparam step_type STEP_MUL_GAIN  = 5'd12;
   localparam step_type STEP_MRES_B    = 5'd13;
   localparam step_type STEP_CLAMP     = 5'd14;
   localparam step_type STEP_ZERO      = 5'd15;
   localparam step_type STEP_EMIT      = 5'd16;
   localparam step_type STEP_RETURN    = 5'd17;

   typedef struct packed {
      op_type    op;
      jcond_type jcond;
      step_type  target;
   } ucode_word_type;

   // microcode rom: a taken jump goes to target, otherwise to the next step
   function automatic ucode_word_type ucode_rom(input step_type step);
      ucode_word_type w;
      case (step)
         STEP_WAIT:      w = '{OP_WAIT,      JC_NO_REQ,    STEP_WAIT};
         STEP_DIV:       w = '{OP_DIV,       JC_DIV_LOOP,  STEP_DIV};
         STEP_QUOT:      w = '{OP_QUOT,      JC_NONE,      STEP_WAIT};
         STEP_MUL_RISE:  w = '{OP_MUL_RISE,  JC_NONE,      STEP_WAIT};
         STEP_MUL_FALL:  w = '{OP_MUL_FALL,  JC_NONE,      STEP_WAIT};
         STEP_UP:        w = '{OP_UP,        JC_NONE,      STEP_WAIT};
         STEP_ACT:       w = '{OP_ACT,       JC_NONE,      STEP_WAIT};
         STEP_THR:       w = '{OP_THR,       JC_NOT_ABOVE, STEP_ZERO};
         STEP_MUL_SLOPE: w = '{OP_MUL_SLOPE, JC_NONE,      STEP_WAIT};
         STEP_MRES_A:    w = '{OP_MRES,      JC_NONE,      STEP_WAIT};
         STEP_ADD_BIAS:  w = '{OP_ADD_BIAS,  JC_NONE,      STEP_WAIT};
         STEP_ADD_RAMP:  w = '{OP_ADD_RAMP,  JC_NONE,      STEP_WAIT};
         STEP_MUL_GAIN:  w = '{OP_MUL_GAIN,  JC_NONE,      STEP_WAIT};
         STEP_MRES_B:    w = '{OP_MRES,      JC_NONE,      STEP_WAIT};
         STEP_CLAMP:     w = '{OP_CLAMP,     JC_ALWAYS,    STEP_EMIT};
         STEP_ZERO:      w = '{OP_ZERO,      JC_NONE,      STEP_WAIT};
         STEP_EMIT:      w = '{OP_EMIT,      JC_OUT_BUSY,  STEP_EMIT};
         STEP_RETURN:    w = '{OP_NOP,       JC_ALWAYS,    STEP_WAIT};
         default:        w = '{OP_NOP,       JC_ALWAYS,    STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ rtl/asymmetric_leaky_threshold_output.sv @@
// ----------------------------------------------------------------------------
// asymmetric_leaky_threshold_output
// Leaky integrator with separate rise and fall coefficients and a
// threshold-linear output, run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
//
// Usage
//   req_*  : one tick per transfer, excitatory and inhibitory drive (unsigned Q15.16).
//   rsp_*  : exactly one result per tick, output value and above-threshold flag.
//   csr_*  : register writes, index 0..7, always ready; write only while idle.
// Timing
//   A result is loaded into the output register after its transfer has passed
//   through the bit-serial divider forming excite / (1 + inhibit) and the
//   microcode steps on the shared multiplier; fewer steps run when the
//   activation does not end above threshold. A new tick is taken only after
//   the result is loaded, so the work on two ticks does not overlap.
// Reset
//   Synchronous active-high reset clears activation, time ramp and the valid
//   flag of the output register, restores register defaults (slope and gain
//   1.0, the rest zero) and restarts the program at its wait step.
// Back-pressure
//   A result waits in the output register while rsp_ready is low; the next
//   tick is taken and worked on meanwhile, and holds at its emit step until
//   the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module asymmetric_leaky_threshold_output
   import alto_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire req_payload_type            req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output rsp_payload_type                 rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [DATA_WIDTH-1:0]      csr_data
);

   localparam logic signed [PROD_WIDTH-1:0] DATA_MAX_W =
      PROD_WIDTH'((PROD_WIDTH'(1) << (DATA_WIDTH - 1)) - 1);
   localparam logic signed [PROD_WIDTH-1:0] DATA_MIN_W = -DATA_MAX_W - 1;
   localparam logic [COEFF_WIDTH-1:0] COEFF_ONE = COEFF_WIDTH'(1) << COEFF_FRAC;
   localparam logic [DATA_WIDTH-1:0]  FIX_ONE   = DATA_WIDTH'(1) << FRAC_BITS;

   // saturate a wide signed value into the data range
   function automatic logic signed [DATA_WIDTH-1:0] sat(
      input logic signed [PROD_WIDTH-1:0] v);
      logic signed [DATA_WIDTH-1:0] r;
      if (v > DATA_MAX_W) begin
         r = DATA_MAX_W[DATA_WIDTH-1:0];
      end else if (v < DATA_MIN_W) begin
         r = DATA_MIN_W[DATA_WIDTH-1:0];
      end else begin
         r = v[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

   // scale a product down, truncating toward zero, then saturate
   function automatic logic signed [DATA_WIDTH-1:0] mres(
      input logic signed [PROD_WIDTH-1:0] p,
      input logic                         coeff_scale);
      logic signed [PROD_WIDTH-1:0] adj;
      logic signed [PROD_WIDTH-1:0] shifted;
      if (coeff_scale) begin
         adj     = p + ((p < 0) ? PROD_WIDTH'((PROD_WIDTH'(1) << COEFF_FRAC) - 1) : '0);
         shifted = adj >>> COEFF_FRAC;
      end else begin
         adj     = p + ((p < 0) ? PROD_WIDTH'((PROD_WIDTH'(1) << FRAC_BITS) - 1) : '0);
         shifted = adj >>> FRAC_BITS;
      end
      return sat(shifted);
   endfunction

   // configuration registers
   logic [COEFF_WIDTH-1:0]       rise_coeff_ff;
   logic [COEFF_WIDTH-1:0]       fall_coeff_ff;
   logic signed [DATA_WIDTH-1:0] threshold_ff;
   logic signed [DATA_WIDTH-1:0] slope_ff;
   logic signed [DATA_WIDTH-1:0] bias_ff;
   logic signed [DATA_WIDTH-1:0] ramp_inc_ff;
   logic [CAP_WIDTH-1:0]         cap_ff;
   logic signed [DATA_WIDTH-1:0] gain_ff;

   // sequencer
   step_type       pc_ff, pc_in;
   ucode_word_type uword;
   logic           jump;

   // divider
   logic [DATA_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIV_BITS-1:0]    quo_ff, quo_in;
   logic [DATA_WIDTH-1:0]  den_ff, den_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [DATA_WIDTH:0]    trial;

   // datapath
   logic signed [DATA_WIDTH-1:0]  act_ff, act_in;
   logic signed [DATA_WIDTH-1:0]  ramp_ff, ramp_in;
   logic signed [DATA_WIDTH-1:0]  s_ff, s_in;
   logic signed [MUL_A_WIDTH-1:0] d_ff, d_in;
   logic signed [PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic signed [DATA_WIDTH-1:0]  m_ff, m_in;
   logic signed [DATA_WIDTH-1:0]  up_ff, up_in;
   logic signed [DATA_WIDTH-1:0]  t_ff, t_in;
   logic [OUT_WIDTH-1:0]          res_ff, res_in;
   logic                          flag_ff, flag_in;
   logic signed [MUL_A_WIDTH-1:0] mul_a;
   logic signed [MUL_B_WIDTH-1:0] mul_b;
   logic signed [PROD_WIDTH-1:0]  mul_p;
   logic [COEFF_WIDTH-1:0]        rise_c;
   logic [COEFF_WIDTH-1:0]        fall_c;
   logic                          above;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            out_busy;

   assign uword     = ucode_rom(pc_ff);
   assign req_ready = (uword.op == OP_WAIT);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_busy  = rsp_valid_ff & ~rsp_ready;
   assign above     = (act_ff > threshold_ff);

   // coefficients above one act as one
   assign rise_c = (rise_coeff_ff > COEFF_ONE) ? COEFF_ONE : rise_coeff_ff;
   assign fall_c = (fall_coeff_ff > COEFF_ONE) ? COEFF_ONE : fall_coeff_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = d_ff;
      mul_b = MUL_B_WIDTH'(rise_c);
      case (uword.op)
         OP_MUL_RISE:  begin
            mul_a = d_ff;
            mul_b = MUL_B_WIDTH'(rise_c);
         end
         OP_MUL_FALL:  begin
            mul_a = d_ff;
            mul_b = MUL_B_WIDTH'(fall_c);
         end
         OP_MUL_SLOPE: begin
            mul_a = MUL_A_WIDTH'(sat(PROD_WIDTH'(d_ff)));
            mul_b = slope_ff;
         end
         OP_MUL_GAIN:  begin
            mul_a = MUL_A_WIDTH'(t_ff);
            mul_b = gain_ff;
         end
         default: ;
      endcase
   end

   assign mul_p = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);

   // restoring divide step
   assign trial = {rem_ff, quo_ff[DIV_BITS-1]} - {1'b0, den_ff};

   // jump condition and next step
   always_comb begin
      case (uword.jcond)
         JC_NONE:      jump = 1'b0;
         JC_ALWAYS:    jump = 1'b1;
         JC_NO_REQ:    jump = ~req_valid;
         JC_DIV_LOOP:  jump = (cnt_ff != '0);
         JC_NOT_ABOVE: jump = ~above;
         JC_OUT_BUSY:  jump = out_busy;
         default:      jump = 1'b1;
      endcase
      pc_in = jump ? uword.target : pc_ff + step_type'(1);
   end

   // datapath controlled by the current control word
   always_comb begin
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      den_in       = den_ff;
      cnt_in       = cnt_ff;
      act_in       = act_ff;
      ramp_in      = ramp_ff;
      s_in         = s_ff;
      d_in         = d_ff;
      prod_in      = prod_ff;
      m_in         = m_ff;
      up_in        = up_ff;
      t_in         = t_ff;
      res_in       = res_ff;
      flag_in      = flag_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (uword.op)
         // load the divider on transfer
         OP_WAIT: begin
            if (req_valid) begin
               rem_in = DATA_WIDTH'(req_data.excite_drive[DRIVE_WIDTH-1:DIV_BITS-FRAC_BITS]);
               quo_in = {req_data.excite_drive[DIV_BITS-FRAC_BITS-1:0],
                         {FRAC_BITS{1'b0}}};
               den_in = FIX_ONE + DATA_WIDTH'(req_data.inhibit_drive);
               cnt_in = CNT_WIDTH'(DIV_BITS - 1);
            end
         end
         // one quotient bit per step
         OP_DIV: begin
            if (!trial[DATA_WIDTH]) begin
               rem_in = trial[DATA_WIDTH-1:0];
               quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[DATA_WIDTH-2:0], quo_ff[DIV_BITS-1]};
               quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_WIDTH'(1);
         end
         OP_QUOT: begin
            s_in = sat(PROD_WIDTH'(quo_ff));
            d_in = MUL_A_WIDTH'(act_ff) - MUL_A_WIDTH'(quo_ff);
         end
         OP_MUL_RISE: begin
            prod_in = mul_p;
         end
         OP_MUL_FALL: begin
            m_in    = mres(prod_ff, 1'b1);
            prod_in = mul_p;
         end
         OP_UP: begin
            up_in = sat(PROD_WIDTH'(s_ff) + PROD_WIDTH'(m_ff));
            m_in  = mres(prod_ff, 1'b1);
         end
         // rise step if it does not lower the activation, else fall step
         OP_ACT: begin
            act_in = (up_ff >= act_ff) ? up_ff : sat(PROD_WIDTH'(s_ff) + PROD_WIDTH'(m_ff));
         end
         OP_THR: begin
            flag_in = above;
            d_in    = MUL_A_WIDTH'(act_ff) - MUL_A_WIDTH'(threshold_ff);
            ramp_in = above ? sat(PROD_WIDTH'(ramp_ff) + PROD_WIDTH'(ramp_inc_ff)) : '0;
         end
         OP_MUL_SLOPE: begin
            prod_in = mul_p;
         end
         OP_MRES: begin
            m_in = mres(prod_ff, 1'b0);
         end
         OP_ADD_BIAS: begin
            t_in = sat(PROD_WIDTH'(m_ff) + PROD_WIDTH'(bias_ff));
         end
         OP_ADD_RAMP: begin
            t_in = sat(PROD_WIDTH'(t_ff) + PROD_WIDTH'(ramp_ff));
         end
         OP_MUL_GAIN: begin
            prod_in = mul_p;
         end
         // clamp at zero and at the cap when set
         OP_CLAMP: begin
            if (m_ff < 0) begin
               res_in = '0;
            end else if ((cap_ff != '0) && (OUT_WIDTH'(m_ff) > cap_ff)) begin
               res_in = cap_ff;
            end else begin
               res_in = OUT_WIDTH'(m_ff);
            end
         end
         OP_ZERO: begin
            res_in = '0;
         end
         OP_EMIT: begin
            if (!out_busy) begin
               rsp_data_in.output_value    = res_ff;
               rsp_data_in.above_threshold = flag_ff;
               rsp_valid_in                = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= STEP_WAIT;
         act_ff        <= '0;
         ramp_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         rise_coeff_ff <= '0;
         fall_coeff_ff <= '0;
         threshold_ff  <= '0;
         slope_ff      <= FIX_ONE;
         bias_ff       <= '0;
         ramp_inc_ff   <= '0;
         cap_ff        <= '0;
         gain_ff       <= FIX_ONE;
      end else begin
         pc_ff        <= pc_in;
         act_ff       <= act_in;
         ramp_ff      <= ramp_in;
         rsp_valid_ff <= rsp_valid_in;
         // register write transfer
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_RISE_COEFF:      rise_coeff_ff <= csr_data[COEFF_WIDTH-1:0];
               CSR_FALL_COEFF:      fall_coeff_ff <= csr_data[COEFF_WIDTH-1:0];
               CSR_THRESHOLD_LEVEL: threshold_ff  <= csr_data;
               CSR_AMPLITUDE_SLOPE: slope_ff      <= csr_data;
               CSR_OUTPUT_BIAS:     bias_ff       <= csr_data;
               CSR_RAMP_INCREMENT:  ramp_inc_ff   <= csr_data;
               CSR_OUTPUT_CAP:      cap_ff        <= csr_data[CAP_WIDTH-1:0];
               CSR_CONTROL_GAIN:    gain_ff       <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      den_ff      <= den_in;
      cnt_ff      <= cnt_in;
      s_ff        <= s_in;
      d_ff        <= d_in;
      prod_ff     <= prod_in;
      m_ff        <= m_in;
      up_ff       <= up_in;
      t_ff        <= t_in;
      res_ff      <= res_in;
      flag_ff     <= flag_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

@@ tb/asymmetric_leaky_threshold_output_tb.sv @@
// ----------------------------------------------------------------------------
// asymmetric_leaky_threshold_output_tb
// Self-checking bench for the leaky integrator with threshold-linear output.
// A short table of ticks at the reset settings runs first. Several register
// settings follow, extremes among them, each with a stream of random ticks.
// Each result is checked against its table row when known, else against a
// bit-exact predictor of the quotient, relaxation, ramp and clamped output.
// ----------------------------------------------------------------------------
`default_nettype none

module asymmetric_leaky_threshold_output_tb;
   import alto_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES     = 11;
   localparam int PHASES           = 13;
   localparam int TICKS_PER_PHASE  = 100;
   localparam int HOLD_OFF_CYCLES  = 400;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int REPORT_LIMIT     = 10;
   localparam int DIRECTED_ROWS    = 15;

   localparam longint DATA_HI     = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
   localparam longint DATA_LO     = -DATA_HI - 1;
   localparam longint OUT_LIMIT   = (64'sd1 <<< OUT_WIDTH) - 1;
   localparam longint ONE_FIX     = 64'sd1 <<< FRAC_BITS;
   localparam longint COEFF_UNITY = 64'sd1 <<< COEFF_FRAC;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [DRIVE_WIDTH-1:0] excite;
      logic [DRIVE_WIDTH-1:0] inhibit;
      bit                     known;
      logic [OUT_WIDTH-1:0]   known_value;
      bit                     known_above;
   } tick_row_type;

   // ticks at the reset settings: both coefficients zero, so the
   // activation follows the quotient and the output equals it when positive
   tick_row_type directed_ticks [DIRECTED_ROWS] = '{
      '{31'h0000_0000, 31'h0000_0000, 1'b1, 31'h0000_0000, 1'b0}, // no drive
      '{31'h0000_0000, 31'h7FFF_FFFF, 1'b1, 31'h0000_0000, 1'b0}, // inhibition only
      '{31'h0001_0000, 31'h0000_0000, 1'b1, 31'h0001_0000, 1'b1}, // unit drive
      '{31'h0000_0001, 31'h0000_0000, 1'b1, 31'h0000_0001, 1'b1}, // smallest step
      '{31'h7FFF_FFFF, 31'h0000_0000, 1'b1, 31'h7FFF_FFFF, 1'b1}, // full drive
      '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, 31'h0000_0000, 1'b0},
      '{31'h0001_0000, 31'h0001_0000, 1'b1, 31'h0000_8000, 1'b1}, // halved
      '{31'h0000_0003, 31'h0001_0000, 1'b0, 31'h0000_0000, 1'b0},
      '{31'h0000_0001, 31'h0000_0001, 1'b1, 31'h0000_0000, 1'b0}, // truncates to zero
      '{31'h5555_5555, 31'h2AAA_AAAA, 1'b0, 31'h0000_0000, 1'b0},
      '{31'h2AAA_AAAA, 31'h5555_5555, 1'b0, 31'h0000_0000, 1'b0},
      '{31'h7FFF_0000, 31'h0000_FFFF, 1'b0, 31'h0000_0000, 1'b0},
      '{31'h1234_5678, 31'h00AB_CDEF, 1'b0, 31'h0000_0000, 1'b0},
      '{31'h4000_0000, 31'h0000_0000, 1'b1, 31'h4000_0000, 1'b1},
      '{31'h0000_0000, 31'h0000_0000, 1'b1, 31'h0000_0000, 1'b0}  // back to rest
   };

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;
   logic            csr_valid;
   logic            csr_ready;
   csr_index_type   csr_index;
   logic [DATA_WIDTH-1:0] csr_data;

   // predictor registers, at their reset values
   logic [COEFF_FRAC:0] rise_k      = '0;
   logic [COEFF_FRAC:0] fall_k      = '0;
   longint              thr_q       = 0;
   longint              slope_q     = ONE_FIX;
   longint              bias_q      = 0;
   longint              ramp_step_q = 0;
   longint              cap_q       = 0;
   longint              gain_q      = ONE_FIX;
   longint              act_level   = 0;
   longint              ramp_level  = 0;

   rsp_payload_type pending_outputs [$];
   int              mismatch_count   = 0;
   int              quiet_cycles     = 0;
   idle_mode_type   idle_mode        = IDLE_NONE;
   bit              hold_off_request = 1'b0;

   asymmetric_leaky_threshold_output i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 4 ns clock
   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   function automatic longint sat_data(longint v);
      if (v > DATA_HI) return DATA_HI;
      if (v < DATA_LO) return DATA_LO;
      return v;
   endfunction

   // exact product, truncated toward zero by sh bits, then saturated
   function automatic longint mul_fix(longint a, longint b, int unsigned sh);
      logic [63:0]  mag_a;
      logic [63:0]  mag_b;
      logic [127:0] mag;
      longint       r;
      mag_a = (a < 0) ? -a : a;
      mag_b = (b < 0) ? -b : b;
      mag   = {64'd0, mag_a} * {64'd0, mag_b};
      mag   = mag >> sh;
      if (mag > 128'(DATA_HI + 1)) r = DATA_HI + 1;
      else r = longint'(mag[63:0]);
      if ((a < 0) != (b < 0)) r = -r;
      return sat_data(r);
   endfunction

   // one exponential-euler step from a toward s, coefficient limited to one
   function automatic longint relax_toward(longint a, longint s, logic [COEFF_FRAC:0] k);
      longint kk;
      kk = longint'({47'd0, k});
      if (kk > COEFF_UNITY) kk = COEFF_UNITY;
      return sat_data(s + mul_fix(a - s, kk, COEFF_FRAC));
   endfunction

   // advances activation and ramp by one tick and returns its result
   function automatic rsp_payload_type integrate_tick(req_payload_type tick);
      logic [63:0]     numer;
      logic [63:0]     denom;
      longint          target;
      longint          lifted;
      longint          term;
      longint          drive_out;
      rsp_payload_type outcome;
      numer  = {33'd0, tick.excite_drive} << FRAC_BITS;
      denom  = 64'(ONE_FIX) + {33'd0, tick.inhibit_drive};
      target = sat_data(longint'(numer / denom));
      lifted = relax_toward(act_level, target, rise_k);
      act_level = (lifted >= act_level) ? lifted : relax_toward(act_level, target, fall_k);
      outcome = '0;
      if (act_level > thr_q) begin
         outcome.above_threshold = 1'b1;
         ramp_level = sat_data(ramp_level + ramp_step_q);
         term = mul_fix(slope_q, sat_data(act_level - thr_q), FRAC_BITS);
         term = sat_data(term + bias_q);
         term = sat_data(term + ramp_level);
         drive_out = mul_fix(gain_q, term, FRAC_BITS);
         if (drive_out < 0) drive_out = 0;
         if (cap_q > 0 && drive_out > cap_q) drive_out = cap_q;
         if (drive_out > OUT_LIMIT) drive_out = OUT_LIMIT;
         outcome.output_value = drive_out[OUT_WIDTH-1:0];
      end else begin
         ramp_level = 0;
      end
      return outcome;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic logic [DATA_WIDTH-1:0] random_coeff();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 32'h0001_0000;
         2:       return $urandom;
         default: return $urandom_range(0, 32'h0001_0000);
      endcase
   endfunction

   // mostly a signed value within +-span, now and then any word at all
   function automatic logic [DATA_WIDTH-1:0] random_word(logic [DATA_WIDTH-1:0] span);
      if ($urandom_range(0, 5) == 0) return $urandom;
      return $urandom_range(0, 2 * span) - span;
   endfunction

   function automatic req_payload_type random_tick();
      logic [31:0]     e;
      logic [31:0]     i;
      req_payload_type tick;
      case ($urandom_range(0, 9))
         0: begin
            e = $urandom;
            i = $urandom;
         end
         1: begin
            e = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0;
            i = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0;
         end
         2, 3, 4, 5: begin
            e = $urandom_range(0, 32'h0006_0000);
            i = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom_range(0, 32'h0003_0000);
         end
         6, 7: begin
            e = $urandom_range(0, 32'h0100_0000);
            i = $urandom_range(0, 32'h0010_0000);
         end
         default: begin
            e = $urandom_range(0, 32'h0000_0800);
            i = $urandom_range(0, 32'h0002_0000);
         end
      endcase
      tick.excite_drive  = e[DRIVE_WIDTH-1:0];
      tick.inhibit_drive = i[DRIVE_WIDTH-1:0];
      return tick;
   endfunction

   // offer one tick, record its expected result on transfer
   task automatic send_tick(input req_payload_type tick, input bit known,
                            input rsp_payload_type known_rsp);
      int              gap;
      int              idle_pct;
      rsp_payload_type predicted;
      gap      = 0;
      idle_pct = (idle_mode == IDLE_SENDER) ? 60 : 26;
      if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
         if ($urandom_range(0, 39) == 0) gap = $urandom_range(20, 120);
         else while ($urandom_range(0, 99) < idle_pct) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= tick;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = integrate_tick(tick);
      pending_outputs.insert(pending_outputs.size(), known ? known_rsp : predicted);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_RISE_COEFF:      rise_k      = value[COEFF_FRAC:0];
         CSR_FALL_COEFF:      fall_k      = value[COEFF_FRAC:0];
         CSR_THRESHOLD_LEVEL: thr_q       = longint'($signed(value));
         CSR_AMPLITUDE_SLOPE: slope_q     = longint'($signed(value));
         CSR_OUTPUT_BIAS:     bias_q      = longint'($signed(value));
         CSR_RAMP_INCREMENT:  ramp_step_q = longint'($signed(value));
         CSR_OUTPUT_CAP:      cap_q       = longint'({33'd0, value[CAP_WIDTH-1:0]});
         CSR_CONTROL_GAIN:    gain_q      = longint'($signed(value));
         default: ;
      endcase
   endtask

   // register settings: a few fixed corners, then random ones
   task automatic configure_phase(input int phase);
      logic [DATA_WIDTH-1:0] reg_value [8];
      csr_index_type         idx;
      case (phase)
         0: begin
            // ordinary working point
            reg_value[CSR_RISE_COEFF]      = 32'h0000_4000;
            reg_value[CSR_FALL_COEFF]      = 32'h0000_C000;
            reg_value[CSR_THRESHOLD_LEVEL] = 32'h0000_8000;
            reg_value[CSR_AMPLITUDE_SLOPE] = 32'h0002_0000;
            reg_value[CSR_OUTPUT_BIAS]     = 32'h0000_0000;
            reg_value[CSR_RAMP_INCREMENT]  = 32'h0000_0100;
            reg_value[CSR_OUTPUT_CAP]      = 32'h0000_0000;
            reg_value[CSR_CONTROL_GAIN]    = 32'h0001_0000;
         end
         1: begin
            // activation frozen, lowest threshold, everything saturating;
            // upper bits beyond the coefficient and cap widths are dropped
            reg_value[CSR_RISE_COEFF]      = 32'h0001_0000;
            reg_value[CSR_FALL_COEFF]      = 32'hFFFF_FFFF;
            reg_value[CSR_THRESHOLD_LEVEL] = 32'h8000_0000;
            reg_value[CSR_AMPLITUDE_SLOPE] = 32'h7FFF_FFFF;
            reg_value[CSR_OUTPUT_BIAS]     = 32'h7FFF_FFFF;
            reg_value[CSR_RAMP_INCREMENT]  = 32'h7FFF_FFFF;
            reg_value[CSR_OUTPUT_CAP]      = 32'h8000_0000;
            reg_value[CSR_CONTROL_GAIN]    = 32'h7FFF_FFFF;
         end
         2: begin
            // highest threshold, never above it
            reg_value[CSR_RISE_COEFF]      = 32'h0000_0000;
            reg_value[CSR_FALL_COEFF]      = 32'h0001_FFFF;
            reg_value[CSR_THRESHOLD_LEVEL] = 32'h7FFF_FFFF;
            reg_value[CSR_AMPLITUDE_SLOPE] = 32'h8000_0000;
            reg_value[CSR_OUTPUT_BIAS]     = 32'h8000_0000;
            reg_value[CSR_RAMP_INCREMENT]  = 32'h8000_0000;
            reg_value[CSR_OUTPUT_CAP]      = 32'h7FFF_FFFF;
            reg_value[CSR_CONTROL_GAIN]    = 32'h8000_0000;
         end
         3: begin
            // negative threshold and slope, falling ramp, cap in use
            reg_value[CSR_RISE_COEFF]      = 32'h0000_F000;
            reg_value[CSR_FALL_COEFF]      = 32'h0000_0800;
            reg_value[CSR_THRESHOLD_LEVEL] = 32'hFFFD_0000;
            reg_value[CSR_AMPLITUDE_SLOPE] = 32'hFFFE_8000;
            reg_value[CSR_OUTPUT_BIAS]     = 32'h0005_0000;
            reg_value[CSR_RAMP_INCREMENT]  = 32'hFFFF_E000;
            reg_value[CSR_OUTPUT_CAP]      = 32'h0002_8000;
            reg_value[CSR_CONTROL_GAIN]    = 32'h0003_0000;
         end
         4: begin
            // ratchet upward only, negative gain, smallest cap
            reg_value[CSR_RISE_COEFF]      = 32'h0000_8000;
            reg_value[CSR_FALL_COEFF]      = 32'h0001_FFFF;
            reg_value[CSR_THRESHOLD_LEVEL] = 32'h0000_0000;
            reg_value[CSR_AMPLITUDE_SLOPE] = 32'h7FFF_FFFF;
            reg_value[CSR_OUTPUT_BIAS]     = 32'h8000_0000;
            reg_value[CSR_RAMP_INCREMENT]  = 32'h0000_1000;
            reg_value[CSR_OUTPUT_CAP]      = 32'h0000_0001;
            reg_value[CSR_CONTROL_GAIN]    = 32'hFFFF_0000;
         end
         default: begin
            reg_value[CSR_RISE_COEFF]      = random_coeff();
            reg_value[CSR_FALL_COEFF]      = random_coeff();
            reg_value[CSR_THRESHOLD_LEVEL] = random_word(32'h0006_0000);
            reg_value[CSR_AMPLITUDE_SLOPE] = random_word(32'h0004_0000);
            reg_value[CSR_OUTPUT_BIAS]     = random_word(32'h0004_0000);
            reg_value[CSR_RAMP_INCREMENT]  = random_word(32'h0000_2000);
            reg_value[CSR_CONTROL_GAIN]    = random_word(32'h0004_0000);
            case ($urandom_range(0, 3))
               0:       reg_value[CSR_OUTPUT_CAP] = '0;
               1:       reg_value[CSR_OUTPUT_CAP] = $urandom;
               default: reg_value[CSR_OUTPUT_CAP] = $urandom_range(1, 32'h0010_0000);
            endcase
         end
      endcase
      idx = idx.first();
      do begin
         write_register(idx, reg_value[idx]);
         idx = idx.next();
      end while (idx != idx.first());
      csr_valid <= 1'b0;
   endtask

   // wait for every outstanding result, then a short pause
   task automatic settle();
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch in %s at %0t: expected %h actual %h", what, $time, want, got);
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      req_payload_type tick;
      rsp_payload_type known_rsp;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_RISE_COEFF;
      csr_data  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table at the reset settings
      foreach (directed_ticks[r]) begin
         tick.excite_drive         = directed_ticks[r].excite;
         tick.inhibit_drive        = directed_ticks[r].inhibit;
         known_rsp.output_value    = directed_ticks[r].known_value;
         known_rsp.above_threshold = directed_ticks[r].known_above;
         send_tick(tick, directed_ticks[r].known, known_rsp);
      end
      req_valid <= 1'b0;
      settle();

      // random ticks under each register setting
      for (int phase = 0; phase < PHASES; phase++) begin
         configure_phase(phase);
         idle_mode = idle_mode_type'(phase % 4);
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            // long receiver hold-off while ticks keep coming
            if (phase == 0 && n == 20) hold_off_request = 1'b1;
            send_tick(random_tick(), 1'b0, '0);
         end
         req_valid <= 1'b0;
         settle();
      end

      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && pending_outputs.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // result receiver: random stalls, bursts, and one long hold-off
   // ---------------------------------------------------------------------
   initial begin
      int stall_len;
      int stall_pct;
      stall_len = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         stall_pct = (idle_mode == IDLE_RECEIVER) ? 60 : 26;
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (stall_len > 0) begin
            rsp_ready <= 1'b0;
            stall_len--;
         end else if ((idle_mode == IDLE_RECEIVER || idle_mode == IDLE_BOTH) &&
                      $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            if ($urandom_range(0, 49) == 0) stall_len = $urandom_range(10, 100);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // result checking and watchdog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end else if (rsp_valid && rsp_ready) begin
            if (pending_outputs.size() == 0) begin
               note_mismatch("result with nothing expected", '0,
                             {1'b0, rsp_data.output_value});
            end else begin
               want = pending_outputs.pop_front();
               if (rsp_data.output_value !== want.output_value)
                  note_mismatch("output_value", {1'b0, want.output_value},
                                {1'b0, rsp_data.output_value});
               if (rsp_data.above_threshold !== want.above_threshold)
                  note_mismatch("above_threshold", {31'd0, want.above_threshold},
                                {31'd0, rsp_data.above_threshold});
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ asymmetric_leaky_threshold_output.f @@
rtl/alto_pkg.sv
rtl/asymmetric_leaky_threshold_output.sv
tb/asymmetric_leaky_threshold_output_tb.sv
